/* sv/a16sf_pkg.sv */
package a16sf_pkg;

    localparam int DATA_W = 16;
    localparam int FLAG_W = 8;
    localparam int OP_W   = 5;

    // condition register bit positions
    localparam int FLAG_C  = 0;
    localparam int FLAG_Z  = 1;
    localparam int FLAG_N  = 2;
    localparam int FLAG_DZ = 3;

    typedef enum logic [OP_W-1:0] {
        OP_AND  = 5'd0,
        OP_NAND = 5'd1,
        OP_OR   = 5'd2,
        OP_XOR  = 5'd3,
        OP_NOT  = 5'd4,
        OP_TCP  = 5'd5,
        OP_SET  = 5'd6,
        OP_SETB = 5'd7,
        OP_CLR  = 5'd8,
        OP_CLRB = 5'd9,
        OP_LLS  = 5'd10,
        OP_LRS  = 5'd11,
        OP_RL   = 5'd12,
        OP_RLC  = 5'd13,
        OP_RR   = 5'd14,
        OP_UMUL = 5'd15,
        OP_SMUL = 5'd16,
        OP_UDIV = 5'd17,
        OP_SDIV = 5'd18,
        OP_ADD  = 5'd19,
        OP_ADDC = 5'd20,
        OP_CMP  = 5'd21,
        OP_SUB  = 5'd22,
        OP_SUBC = 5'd23,
        OP_RSUB = 5'd24,
        OP_RSBC = 5'd25,
        OP_INC  = 5'd26,
        OP_DEC  = 5'd27,
        OP_LDF  = 5'd28
    } t_op;

    typedef struct packed {
        logic [DATA_W-1:0] value;     // drives the flag update
        logic [DATA_W-1:0] ret;       // returned to the output
        logic              carry;
        logic              rlc;       // carry is replaced, not ORed
        logic              rlc_carry;
        logic              dz;
    } t_alu_res;

    typedef struct packed {
        logic              busy;
        logic [DATA_W-1:0] quo;
    } t_div_stat;

endpackage

/* sv/alu16_with_sticky_flags.sv */
// An accepted item is registered, then S_EXEC writes its result back to the
// result register; UDIV and SDIV with a nonzero divisor instead wait in S_DIV
// for the divider to finish; a stalled output result delays the write-back.
// One item at a time; a new item is taken the cycle after the previous one
// completes.
// Reset (synchronous, active low) clears the condition register, drops the
// output valid and returns the sequencer to idle.
module alu16_with_sticky_flags (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [a16sf_pkg::OP_W-1:0]   i_op,
    input  logic [a16sf_pkg::DATA_W-1:0] i_left,
    input  logic [a16sf_pkg::DATA_W-1:0] i_right,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [a16sf_pkg::DATA_W-1:0] o_result,
    output logic [a16sf_pkg::FLAG_W-1:0] o_flags
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV
    } t_state;

    t_state                       r_state;
    logic                         r_out_valid;
    logic [a16sf_pkg::FLAG_W-1:0] r_cond;
    logic [a16sf_pkg::DATA_W-1:0] r_result;
    logic [a16sf_pkg::OP_W-1:0]   r_op;
    logic [a16sf_pkg::DATA_W-1:0] r_left;
    logic [a16sf_pkg::DATA_W-1:0] r_right;
    logic                         r_neg;

    logic                         accept;
    logic                         is_div;
    logic                         is_sdiv;
    logic                         div_start;
    logic [a16sf_pkg::DATA_W-1:0] mag_l;
    logic [a16sf_pkg::DATA_W-1:0] mag_r;
    logic [a16sf_pkg::DATA_W-1:0] div_q;
    logic                         out_free;
    logic                         finish;
    logic [a16sf_pkg::FLAG_W-1:0] n_cond;
    a16sf_pkg::t_div_stat         div_stat;
    a16sf_pkg::t_alu_res          alu_res;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    assign is_sdiv   = (i_op == a16sf_pkg::OP_SDIV);
    assign is_div    = (i_op == a16sf_pkg::OP_UDIV) || is_sdiv;
    assign div_start = accept && is_div && (i_right != '0);

    // SDIV runs on magnitudes; the quotient sign is fixed afterwards
    assign mag_l = (is_sdiv && i_left[a16sf_pkg::DATA_W-1])  ? -i_left  : i_left;
    assign mag_r = (is_sdiv && i_right[a16sf_pkg::DATA_W-1]) ? -i_right : i_right;
    assign div_q = r_neg ? -div_stat.quo : div_stat.quo;

    a16sf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mag_l),
        .i_divisor  (mag_r),
        .o_stat     (div_stat)
    );

    a16sf_alu u_alu (
        .i_op    (r_op),
        .i_left  (r_left),
        .i_right (r_right),
        .i_carry (r_cond[a16sf_pkg::FLAG_C]),
        .i_div_q (div_q),
        .o_res   (alu_res)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign finish   = out_free &&
                      ((r_state == S_EXEC) || ((r_state == S_DIV) && !div_stat.busy));

    always_comb begin
        n_cond = r_cond;
        if (r_op == a16sf_pkg::OP_LDF) begin
            n_cond = r_left[a16sf_pkg::FLAG_W-1:0];
        end else begin
            if (alu_res.rlc) begin
                n_cond[a16sf_pkg::FLAG_C] = alu_res.rlc_carry;
            end
            n_cond[a16sf_pkg::FLAG_C]  = n_cond[a16sf_pkg::FLAG_C] | alu_res.carry;
            n_cond[a16sf_pkg::FLAG_Z]  = n_cond[a16sf_pkg::FLAG_Z] | (alu_res.value == '0);
            n_cond[a16sf_pkg::FLAG_N]  = n_cond[a16sf_pkg::FLAG_N] |
                                         alu_res.value[a16sf_pkg::DATA_W-1];
            n_cond[a16sf_pkg::FLAG_DZ] = n_cond[a16sf_pkg::FLAG_DZ] | alu_res.dz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cond      <= '0;
        end else begin
            unique case (r_state) inside
                S_IDLE: begin
                    if (accept) begin
                        r_state <= div_start ? S_DIV : S_EXEC;
                    end
                end
                S_EXEC, S_DIV: begin
                    if (finish) begin
                        r_state  <= S_IDLE;
                        r_cond   <= n_cond;
                        r_result <= (r_op == a16sf_pkg::OP_LDF) ? '0 : alu_res.ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // raise valid with a fresh result, drop it once taken
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_left  <= i_left;
            r_right <= i_right;
            r_neg   <= is_sdiv && (i_left[a16sf_pkg::DATA_W-1] ^ i_right[a16sf_pkg::DATA_W-1]);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign o_flags     = r_cond;

endmodule

/* sv/a16sf_div.sv */
module a16sf_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [a16sf_pkg::DATA_W-1:0] i_dividend,
    input  logic [a16sf_pkg::DATA_W-1:0] i_divisor,
    output a16sf_pkg::t_div_stat         o_stat
);

    localparam int CNT_W = $clog2(a16sf_pkg::DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(a16sf_pkg::DATA_W - 1);

    logic                         r_busy;
    logic [CNT_W-1:0]             r_cnt;
    logic [a16sf_pkg::DATA_W-1:0] r_rem;
    logic [a16sf_pkg::DATA_W-1:0] r_quo;
    logic [a16sf_pkg::DATA_W-1:0] r_dsr;
    logic [a16sf_pkg::DATA_W+1:0] trial;

    // shift in the next dividend bit and try to subtract the divisor
    assign trial = {1'b0, r_rem, r_quo[a16sf_pkg::DATA_W-1]} - {2'b00, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            if (!trial[a16sf_pkg::DATA_W+1]) begin
                r_rem <= trial[a16sf_pkg::DATA_W-1:0];
                r_quo <= {r_quo[a16sf_pkg::DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[a16sf_pkg::DATA_W-2:0], r_quo[a16sf_pkg::DATA_W-1]};
                r_quo <= {r_quo[a16sf_pkg::DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.quo  = r_quo;

endmodule

/* sv/a16sf_alu.sv */
module a16sf_alu (
    input  logic [a16sf_pkg::OP_W-1:0]   i_op,
    input  logic [a16sf_pkg::DATA_W-1:0] i_left,
    input  logic [a16sf_pkg::DATA_W-1:0] i_right,
    input  logic                         i_carry,
    input  logic [a16sf_pkg::DATA_W-1:0] i_div_q,
    output a16sf_pkg::t_alu_res          o_res
);

    logic               big;
    logic [3:0]         sh;
    logic [15:0]        bit_mask;
    logic [31:0]        rl_w;
    logic [31:0]        rr_w;
    logic [8:0]         m1;
    logic [7:0]         m2;
    logic [5:0]         m3;
    logic [4:0]         s17;
    logic [16:0]        rx;
    logic [33:0]        ry;
    logic [16:0]        rot;
    logic signed [15:0] sprod;
    logic [16:0]        w;

    assign big      = |i_right[15:4];
    assign sh       = i_right[3:0];
    assign bit_mask = 16'h0001 << sh;
    assign rl_w     = {i_left, i_left} << sh;
    assign rr_w     = {i_left, i_left} >> sh;

    // right mod 17: 256 and 1 are congruent, 16 and -1 are congruent
    assign m1  = {1'b0, i_right[15:8]} + {1'b0, i_right[7:0]};
    assign m2  = m1[7:0] + {7'd0, m1[8]};
    assign m3  = {2'b00, m2[3:0]} + 6'd17 - {2'b00, m2[7:4]};
    assign s17 = (m3 >= 6'd17) ? 5'(m3 - 6'd17) : m3[4:0];

    assign rx  = {i_carry, i_left};
    assign ry  = {rx, rx} << s17;
    assign rot = ry[33:17];

    assign sprod = $signed({{8{i_left[7]}}, i_left[7:0]}) *
                   $signed({{8{i_right[7]}}, i_right[7:0]});

    always_comb begin
        w               = '0;
        o_res.value     = '0;
        o_res.carry     = 1'b0;
        o_res.rlc       = 1'b0;
        o_res.rlc_carry = rot[16];
        o_res.dz        = 1'b0;
        unique case (i_op) inside
            a16sf_pkg::OP_AND:  o_res.value = i_left & i_right;
            a16sf_pkg::OP_NAND: o_res.value = ~(i_left & i_right);
            a16sf_pkg::OP_OR:   o_res.value = i_left | i_right;
            a16sf_pkg::OP_XOR:  o_res.value = i_left ^ i_right;
            a16sf_pkg::OP_NOT:  o_res.value = ~i_left;
            a16sf_pkg::OP_TCP:  o_res.value = 16'd0 - i_left;
            a16sf_pkg::OP_SET:  o_res.value = 16'hffff;
            a16sf_pkg::OP_SETB: o_res.value = big ? i_left : (i_left | bit_mask);
            a16sf_pkg::OP_CLR:  o_res.value = '0;
            a16sf_pkg::OP_CLRB: o_res.value = big ? i_left : (i_left & ~bit_mask);
            a16sf_pkg::OP_LLS:  o_res.value = big ? 16'd0 : (i_left << sh);
            a16sf_pkg::OP_LRS:  o_res.value = big ? 16'd0 : (i_left >> sh);
            a16sf_pkg::OP_RL:   o_res.value = rl_w[31:16];
            a16sf_pkg::OP_RLC: begin
                o_res.value = rot[15:0];
                o_res.rlc   = 1'b1;
            end
            a16sf_pkg::OP_RR:   o_res.value = rr_w[15:0];
            a16sf_pkg::OP_UMUL: o_res.value = {8'd0, i_left[7:0]} * {8'd0, i_right[7:0]};
            a16sf_pkg::OP_SMUL: o_res.value = sprod;
            a16sf_pkg::OP_UDIV, a16sf_pkg::OP_SDIV: begin
                o_res.dz    = (i_right == 16'd0);
                o_res.value = o_res.dz ? 16'd0 : i_div_q;
            end
            a16sf_pkg::OP_ADD:  w = {1'b0, i_left} + {1'b0, i_right};
            a16sf_pkg::OP_ADDC: w = {1'b0, i_left} + {1'b0, i_right} + {16'd0, i_carry};
            a16sf_pkg::OP_CMP, a16sf_pkg::OP_SUB:
                w = {1'b0, i_left} - {1'b0, i_right};
            a16sf_pkg::OP_SUBC: w = {1'b0, i_left} - {1'b0, i_right} - {16'd0, i_carry};
            a16sf_pkg::OP_RSUB: w = {1'b0, i_right} - {1'b0, i_left};
            a16sf_pkg::OP_RSBC: w = {1'b0, i_right} - {1'b0, i_left} - {16'd0, i_carry};
            a16sf_pkg::OP_INC:  w = {1'b0, i_left} + 17'd1;
            a16sf_pkg::OP_DEC:  w = {1'b0, i_left} - 17'd1;
            default:            o_res.value = '0;
        endcase
        case (i_op) inside
            a16sf_pkg::OP_ADD, a16sf_pkg::OP_ADDC, a16sf_pkg::OP_CMP, a16sf_pkg::OP_SUB,
            a16sf_pkg::OP_SUBC, a16sf_pkg::OP_RSUB, a16sf_pkg::OP_RSBC, a16sf_pkg::OP_INC,
            a16sf_pkg::OP_DEC: begin
                o_res.value = w[15:0];
                o_res.carry = w[16];
            end
            default: ;
        endcase
        // compare returns left but flags follow the difference
        o_res.ret = (i_op == a16sf_pkg::OP_CMP) ? i_left : o_res.value;
    end

endmodule

/* sv/a16sf_chk.sv */
module a16sf_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_stall,
    input logic                         i_out_valid,
    input logic                         i_out_stall,
    input logic [a16sf_pkg::DATA_W-1:0] i_result,
    input logic [a16sf_pkg::FLAG_W-1:0] i_flags
);

    // reset empties the output and clears the condition register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && (i_flags == '0))
        else $error("output or flags not cleared by reset");

    // one item in flight: stall right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("second item taken while one is in flight");

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_result) && $stable(i_flags))
        else $error("stalled result changed");

    // flags change only together with a fresh result
    a_flags_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(i_flags) |->
            i_out_valid && !$past(i_out_valid && i_out_stall))
        else $error("flags changed without a new result");

endmodule

bind alu16_with_sticky_flags a16sf_chk u_a16sf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_result    (o_result),
    .i_flags     (o_flags)
);
